/* hdl/mrr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_pkg: shared types for the Miller-Rabin round block
// Payload structs and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package mrr_pkg;

  typedef struct packed {
    logic [63:0] candidate;
    logic [63:0] witness;
  } in_item_t;

  typedef struct packed {
    logic probably_prime;
    logic trivial_case;
  } out_item_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,     // latch n, a; d = n-1
    OP_SHIFT_D,  // d >>= 1, s++
    OP_REDUCE,   // b = a mod n (via multiply by 1)
    OP_MUL_XB,   // x = x*b mod n
    OP_MUL_BB,   // b = b*b mod n, e >>= 1
    OP_MUL_XX    // x = x*x mod n, r++
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;      // modular multiply in progress
    logic d_odd;
    logic e_zero;
    logic e_lsb;
    logic x_one;
    logic x_top;
    logic r_done;    // r >= s
  } dp_sts_t;

endpackage

/* hdl/mrr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_datapath: registers and shared bit-serial modular multiplier
// One multiplier bit per cycle, WIDTH multiplier bits per modular product.
// ----------------------------------------------------------------------------
module mrr_datapath #(
  parameter int WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrr_pkg::dp_cmd_t   cmd_i,
  input  logic [WIDTH-1:0]   cand_i,
  input  logic [WIDTH-1:0]   wit_i,
  output mrr_pkg::dp_sts_t   sts_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] n_q, a_q, d_q, e_q, x_q, b_q;
  logic [CW-1:0]    s_q, r_q;

  // multiplier state
  logic             busy_q;
  mrr_pkg::dp_op_e  mop_q;
  logic [WIDTH-1:0] p_q, q_q, acc_q;
  logic [CW-1:0]    cnt_q;

  // acc = 2*acc mod n, then + p mod n if bit set
  logic [WIDTH:0]   dbl, dred, sum, sred;
  logic [WIDTH-1:0] acc1, acc2;
  always_comb begin
    dbl  = {acc_q, 1'b0};
    dred = dbl - {1'b0, n_q};
    acc1 = (dbl >= {1'b0, n_q}) ? dred[WIDTH-1:0] : dbl[WIDTH-1:0];
    sum  = {1'b0, acc1} + {1'b0, p_q};
    sred = sum - {1'b0, n_q};
    if (q_q[WIDTH-1]) begin
      acc2 = (sum >= {1'b0, n_q}) ? sred[WIDTH-1:0] : sum[WIDTH-1:0];
    end else begin
      acc2 = acc1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mop_q  <= mrr_pkg::OP_NONE;
      cnt_q  <= '0;
    end else if (busy_q) begin
      acc_q <= acc2;
      q_q   <= q_q << 1;
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        case (mop_q)
          mrr_pkg::OP_REDUCE, mrr_pkg::OP_MUL_BB: b_q <= acc2;
          mrr_pkg::OP_MUL_XB, mrr_pkg::OP_MUL_XX: x_q <= acc2;
          default: ;
        endcase
      end
    end else begin
      case (cmd_i.op)
        mrr_pkg::OP_LOAD: begin
          n_q <= cand_i;
          a_q <= wit_i;
          d_q <= cand_i - 1'b1;
          s_q <= '0;
          r_q <= CW'(1);
          x_q <= WIDTH'(1);
        end
        mrr_pkg::OP_SHIFT_D: begin
          d_q <= d_q >> 1;
          s_q <= s_q + 1'b1;
        end
        mrr_pkg::OP_REDUCE: begin
          // a*1 mod n: a goes in as the multiplier since a may exceed n; use q=a, p=1
          e_q <= d_q;
        end
        mrr_pkg::OP_MUL_BB: e_q <= e_q >> 1;
        mrr_pkg::OP_MUL_XX: r_q <= r_q + 1'b1;
        default: ;
      endcase
      if (cmd_i.op == mrr_pkg::OP_REDUCE || cmd_i.op == mrr_pkg::OP_MUL_XB ||
          cmd_i.op == mrr_pkg::OP_MUL_BB || cmd_i.op == mrr_pkg::OP_MUL_XX) begin
        busy_q <= 1'b1;
        mop_q  <= cmd_i.op;
        cnt_q  <= CW'(WIDTH);
        acc_q  <= '0;
        case (cmd_i.op)
          mrr_pkg::OP_REDUCE: begin p_q <= WIDTH'(1); q_q <= a_q; end
          mrr_pkg::OP_MUL_XB: begin p_q <= x_q; q_q <= b_q; end
          mrr_pkg::OP_MUL_BB: begin p_q <= b_q; q_q <= b_q; end
          default:            begin p_q <= x_q; q_q <= x_q; end
        endcase
      end
    end
  end

  assign sts_o.busy   = busy_q;
  assign sts_o.d_odd  = d_q[0];
  assign sts_o.e_zero = (e_q == '0);
  assign sts_o.e_lsb  = e_q[0];
  assign sts_o.x_one  = (x_q == WIDTH'(1));
  assign sts_o.x_top  = (x_q == n_q - 1'b1);
  assign sts_o.r_done = (r_q >= s_q);

endmodule

/* hdl/mrr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_ctrl: sequencer for one Miller-Rabin round
// Handles the trivial cases, then steps the datapath through the powering
// and squaring loops and holds the verdict for the output channel.
// ----------------------------------------------------------------------------
module mrr_ctrl #(
  parameter int WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [WIDTH-1:0]   cand_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mrr_pkg::out_item_t out_data_o,
  output mrr_pkg::dp_cmd_t   cmd_o,
  input  mrr_pkg::dp_sts_t   sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPLIT, ST_REDUCE, ST_POW, ST_POW_W1, ST_POW_W2,
    ST_CHECK, ST_SQ, ST_SQ_W, ST_DONE
  } state_e;

  state_e             state_q;
  logic               outv_q;
  mrr_pkg::out_item_t res_q;

  // trivial decode on the incoming candidate
  logic is23, triv;
  assign is23 = (cand_i == WIDTH'(2)) || (cand_i == WIDTH'(3));
  assign triv = is23 || !cand_i[0] || (cand_i == WIDTH'(1));

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && !outv_q;

  // command decode
  always_comb begin
    cmd_o.op = mrr_pkg::OP_NONE;
    case (state_q)
      ST_IDLE:   if (in_fire && !triv) cmd_o.op = mrr_pkg::OP_LOAD;
      ST_SPLIT:  if (!sts_i.d_odd) cmd_o.op = mrr_pkg::OP_SHIFT_D;
      ST_REDUCE: cmd_o.op = mrr_pkg::OP_REDUCE;
      ST_POW: begin
        if (!sts_i.busy && !sts_i.e_zero) begin
          cmd_o.op = sts_i.e_lsb ? mrr_pkg::OP_MUL_XB : mrr_pkg::OP_MUL_BB;
        end
      end
      ST_POW_W1: if (!sts_i.busy) cmd_o.op = mrr_pkg::OP_MUL_BB;
      ST_SQ:     cmd_o.op = mrr_pkg::OP_MUL_XX;
      default: ;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      outv_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      if (outv_q && out_ready_i) outv_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (triv) begin
              outv_q <= 1'b1;
              res_q.probably_prime <= is23;
              res_q.trivial_case   <= 1'b1;
            end else begin
              state_q <= ST_SPLIT;
            end
          end
        end
        ST_SPLIT:  if (sts_i.d_odd) state_q <= ST_REDUCE;
        ST_REDUCE: state_q <= ST_POW_W2;
        ST_POW_W2: if (!sts_i.busy) state_q <= ST_POW;
        ST_POW: begin
          if (!sts_i.busy) begin
            if (sts_i.e_zero) state_q <= ST_CHECK;
            else if (sts_i.e_lsb) state_q <= ST_POW_W1;
            else state_q <= ST_POW_W2;
          end
        end
        ST_POW_W1: if (!sts_i.busy) state_q <= ST_POW_W2;
        ST_CHECK: begin
          if (sts_i.x_one || sts_i.x_top) begin
            res_q <= '{probably_prime: 1'b1, trivial_case: 1'b0};
            state_q <= ST_DONE;
          end else if (sts_i.r_done) begin
            res_q <= '{probably_prime: 1'b0, trivial_case: 1'b0};
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SQ;
          end
        end
        ST_SQ: state_q <= ST_SQ_W;
        ST_SQ_W: begin
          if (!sts_i.busy) begin
            if (sts_i.x_one) begin
              res_q <= '{probably_prime: 1'b0, trivial_case: 1'b0};
              state_q <= ST_DONE;
            end else if (sts_i.x_top) begin
              res_q <= '{probably_prime: 1'b1, trivial_case: 1'b0};
              state_q <= ST_DONE;
            end else if (sts_i.r_done) begin
              res_q <= '{probably_prime: 1'b0, trivial_case: 1'b0};
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_SQ;
            end
          end
        end
        ST_DONE: begin
          outv_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = outv_q;
  assign out_data_o  = res_q;

endmodule

/* hdl/miller_rabin_round_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_round_core: one Miller-Rabin round on a WIDTH-bit candidate
//
// Input channel (in_valid_i/in_ready_o/in_data_i) carries candidate and
// witness; output channel (out_valid_o/out_ready_i/out_data_o) returns one
// verdict per transaction. One transaction is worked on at a time.
// Trivial candidates (below 4 or even) answer in the cycle after acceptance.
// Others take roughly (2*bitlen(d) + 1 + s) modular products, each from a
// single shared bit-serial multiplier, after n-1 is split into d * 2^s.
// The result sits in an output register until taken; while it waits the
// input is not ready. Reset returns the sequencer to idle with no result.
// ----------------------------------------------------------------------------
module miller_rabin_round_core #(
  parameter int WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mrr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mrr_pkg::out_item_t out_data_o
);

  mrr_pkg::dp_cmd_t cmd;
  mrr_pkg::dp_sts_t sts;
  logic [WIDTH-1:0] cand, wit;

  assign cand = in_data_i.candidate[WIDTH-1:0];
  assign wit  = in_data_i.witness[WIDTH-1:0];

  mrr_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .cand_i(cand), .out_valid_o, .out_ready_i, .out_data_o,
    .cmd_o(cmd), .sts_i(sts)
  );

  mrr_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cand_i(cand), .wit_i(wit), .sts_o(sts)
  );

  // no new transaction while a verdict waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready with result pending");

  // multiplier never started while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.busy |-> cmd.op == mrr_pkg::OP_NONE) else $error("command while busy");

  // trivial verdict never claims prime on an even candidate other than 2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !in_data_i.candidate[0] &&
     in_data_i.candidate[WIDTH-1:0] != WIDTH'(2))
    |=> out_valid_o && !out_data_o.probably_prime) else $error("bad even verdict");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for miller_rabin_round_core
// Drives candidate/witness transactions with random idle bursts on both
// channels, predicts each verdict with a behavioral Miller-Rabin round and
// checks every returned transaction in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int WIDTH = 64;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  mrr_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  mrr_pkg::out_item_t out_data_o;

  mrr_pkg::in_item_t  pending_q[$];
  mrr_pkg::out_item_t verdict_q[$];
  int                 err_cnt;
  bit                 calm;
  int                 in_idle;
  int                 out_idle;

  miller_rabin_round_core #(.WIDTH(WIDTH)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // exact modular product through a 128-bit intermediate
  function automatic logic [63:0] mulmod(logic [63:0] p, logic [63:0] q, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, p} * {64'd0, q};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic mrr_pkg::out_item_t round_verdict(mrr_pkg::in_item_t it);
    logic [63:0]        n, a, d, top, x, b, e;
    int                 s;
    mrr_pkg::out_item_t v;
    n = it.candidate;
    a = it.witness;
    v = '0;
    if (n == 64'd2 || n == 64'd3) begin
      v.probably_prime = 1'b1;
      v.trivial_case = 1'b1;
      return v;
    end
    if (n <= 64'd1 || !n[0]) begin
      v.trivial_case = 1'b1;
      return v;
    end
    top = n - 64'd1;
    d = top;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    x = 64'd1;
    b = a % n;
    e = d;
    while (e != 0) begin
      if (e[0]) x = mulmod(x, b, n);
      e = e >> 1;
      b = mulmod(b, b, n);
    end
    if (x == 64'd1 || x == top) begin
      v.probably_prime = 1'b1;
    end else begin
      for (int r = 1; r < s; r++) begin
        x = mulmod(x, x, n);
        if (x == 64'd1) break;
        if (x == top) begin
          v.probably_prime = 1'b1;
          break;
        end
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic mrr_pkg::in_item_t mk(logic [63:0] n, logic [63:0] a);
    mrr_pkg::in_item_t it;
    it.candidate = n;
    it.witness = a;
    return it;
  endfunction

  // driver: present pending transactions, with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      in_idle <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        verdict_q.push_back(round_verdict(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_idle > 0) begin
          in_idle <= in_idle - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
          in_idle <= $urandom_range(1, 10) - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_data_i <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: take verdicts with random stall bursts and check them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_idle <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict %b", $time, out_data_o);
          err_cnt++;
        end else begin
          mrr_pkg::out_item_t exp_v;
          exp_v = verdict_q.pop_front();
          if (out_data_o.probably_prime !== exp_v.probably_prime) begin
            $display("%0t: probably_prime expected %b actual %b", $time,
                     exp_v.probably_prime, out_data_o.probably_prime);
            err_cnt++;
          end
          if (out_data_o.trivial_case !== exp_v.trivial_case) begin
            $display("%0t: trivial_case expected %b actual %b", $time,
                     exp_v.trivial_case, out_data_o.trivial_case);
            err_cnt++;
          end
        end
      end
      if (out_idle > 0) begin
        out_idle <= out_idle - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_idle <= $urandom_range(1, 10) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    logic [63:0] n;
    logic [63:0] primes[6];
    primes = '{64'd5, 64'd97, 64'd65537, 64'd2147483647,
               64'd2305843009213693951, 64'hFFFF_FFFF_FFFF_FFC5};
    err_cnt = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // trivial candidates and field extremes
    pending_q.push_back(mk(64'd0, 64'd5));
    pending_q.push_back(mk(64'd1, 64'd0));
    pending_q.push_back(mk(64'd2, '1));
    pending_q.push_back(mk(64'd3, 64'd2));
    pending_q.push_back(mk(64'd4, 64'd3));
    pending_q.push_back(mk('1 - 64'd1, '1));
    pending_q.push_back(mk('1, '1));
    pending_q.push_back(mk('1, 64'd0));
    // witness reduces to zero, to one, or sits above the candidate
    pending_q.push_back(mk(64'd97, 64'd97 * 64'd3));
    pending_q.push_back(mk(64'd97, 64'd98));
    pending_q.push_back(mk(64'd97, 64'd1));
    pending_q.push_back(mk(64'd97, 64'd96));
    pending_q.push_back(mk(64'd5, '1));
    // strong pseudoprime to base 2, ordinary composites and large primes
    pending_q.push_back(mk(64'd2047, 64'd2));
    pending_q.push_back(mk(64'd2047, 64'd3));
    pending_q.push_back(mk(64'd561, 64'd7));
    pending_q.push_back(mk(64'd9, 64'd8));
    pending_q.push_back(mk(64'hFFFF_FFFF_FFFF_FFC5, 64'h1234_5678_9ABC_DEF1));
    pending_q.push_back(mk(64'd2305843009213693951, 64'd3));
    pending_q.push_back(mk(64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA));

    // random: mostly odd candidates, some primes, some noise
    for (int i = 0; i < 80; i++) begin
      case ($urandom_range(0, 9))
        0: n = 64'($urandom_range(0, 20));
        1, 2: n = primes[$urandom_range(0, 5)];
        3: n = rnd64() & ~64'd1;
        default: n = rnd64() | 64'd1;
      endcase
      pending_q.push_back(mk(n, rnd64()));
      if (i == 60) begin
        wait (pending_q.size() <= 20);
        calm = 1'b1;
      end
    end

    wait (pending_q.size() == 0 && !in_valid_i);
    wait (verdict_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // overall time limit for ~100 items, with margin
  initial begin
    #200ms;
    $display("tb: done, errors");
    $finish;
  end
endmodule

/* filelist.f */
hdl/mrr_pkg.sv
hdl/mrr_datapath.sv
hdl/mrr_ctrl.sv
hdl/miller_rabin_round_core.sv
verif/tb.sv
